>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the pattern search block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while en is low
`define ASSERT_IMPL(lbl, clk, en, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(en)) (a) |-> (c)) \
        else $error(msg);

// next-cycle implication, disabled while en is low
`define ASSERT_NEXT(lbl, clk, en, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(en)) (a) |=> (c)) \
        else $error(msg);

`endif

>>> rtl/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// widths, register indexes and helpers for the wildcard byte pattern search
// ----------------------------------------------------------------------------
package wbps_pkg;

    localparam int DATA_W    = 8;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int LEN_W     = 6;
    localparam int OFS_W     = 16;
    localparam int CNT_W     = 32;
    localparam int ADDR_W    = 33;
    localparam int PAT_REGS  = 4;
    localparam int PAT_IDX_W = 5;

    typedef logic [DATA_W-1:0]                t_byte;
    typedef logic [CFG_IDX_W-1:0]             t_cfg_idx;
    typedef logic [PAT_REGS-1:0][CFG_W-1:0]   t_pat_regs;

    localparam t_cfg_idx REG_PAT0   = 3'd0;
    localparam t_cfg_idx REG_PAT1   = 3'd1;
    localparam t_cfg_idx REG_PAT2   = 3'd2;
    localparam t_cfg_idx REG_PAT3   = 3'd3;
    localparam t_cfg_idx REG_LEN    = 3'd4;
    localparam t_cfg_idx REG_WILD   = 3'd5;
    localparam t_cfg_idx REG_OFFSET = 3'd6;

    function automatic t_byte pat_byte(input t_pat_regs p, input logic [PAT_IDX_W-1:0] k);
        pat_byte = p[k[4:3]][{k[2:0], 3'b000} +: DATA_W];
    endfunction

endpackage

>>> rtl/wildcard_byte_pattern_search_core.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search_core
// scans a byte stream for a pattern with wildcard bytes, one result per region
// ----------------------------------------------------------------------------
// usage
//   input channel: one data byte per request, i_region_end on the last byte
//   output channel: one request per region with o_found and o_match_address
//   config port: i_cfg_we writes i_cfg_data to register i_cfg_idx; the user must write
//   only while the block is idle (no region in flight), the block does not enforce it
// timing
//   one byte accepted every cycle while o_ready is high; a byte is held in the
//   input register, then the window compare and position update go into the
//   state and result registers, so a region's result is registered in the result
//   register when its last byte leaves the input register
//   the aligned pattern/care registers are registered from the config registers
// reset
//   synchronous, clears the config registers, counters and both valid flags
// stall
//   while a result waits, non-final bytes keep flowing; a second region end
//   holds in the input register and o_ready drops until the result is taken
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_search_core #(
    parameter int MAX_PATTERN = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  wbps_pkg::t_cfg_idx      i_cfg_idx,
    input  logic [wbps_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  wbps_pkg::t_byte         i_data_byte,
    input  logic                    i_region_end,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_found,
    output logic [wbps_pkg::ADDR_W-1:0] o_match_address
);
    import wbps_pkg::*;

    // config
    t_pat_regs          r_pat;
    logic [LEN_W-1:0]   r_len;
    t_byte              r_wild;
    logic [OFS_W-1:0]   r_ofs;

    // pattern realigned to window age
    t_byte              r_cmp_pat  [MAX_PATTERN];
    logic               r_cmp_care [MAX_PATTERN];
    logic               r_len_ok;
    t_byte              n_cmp_pat  [MAX_PATTERN];
    logic               n_cmp_care [MAX_PATTERN];
    logic               n_len_ok;

    // input register
    logic               r_in_valid;
    t_byte              r_in_byte;
    logic               r_in_end;

    // region state
    t_byte              r_win [MAX_PATTERN];
    t_byte              n_win [MAX_PATTERN];
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_seen;
    logic               n_seen;
    logic [CNT_W-1:0]   r_pos;
    logic [CNT_W-1:0]   n_pos;

    // result register
    logic               r_out_valid;
    logic               r_out_found;
    logic [ADDR_W-1:0]  r_out_addr;

    logic               out_free;
    logic               adv;
    logic               win_ok;
    logic               hit;

    // config write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_len  <= '0;
            r_wild <= '0;
            r_ofs  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PAT0:   r_pat[0] <= i_cfg_data;
                REG_PAT1:   r_pat[1] <= i_cfg_data;
                REG_PAT2:   r_pat[2] <= i_cfg_data;
                REG_PAT3:   r_pat[3] <= i_cfg_data;
                REG_LEN:    r_len    <= i_cfg_data[LEN_W-1:0];
                REG_WILD:   r_wild   <= i_cfg_data[DATA_W-1:0];
                REG_OFFSET: r_ofs    <= i_cfg_data[OFS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // window age a compares with pattern byte len-1-a
    always_comb begin
        logic [LEN_W-1:0] idx;
        n_len_ok = (r_len != '0) && (r_len <= LEN_W'(MAX_PATTERN));
        for (int a = 0; a < MAX_PATTERN; a++) begin
            idx           = r_len - LEN_W'(a) - LEN_W'(1);
            n_cmp_pat[a]  = pat_byte(r_pat, idx[PAT_IDX_W-1:0]);
            n_cmp_care[a] = (LEN_W'(a) < r_len) && (n_cmp_pat[a] != r_wild);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_pat  <= n_cmp_pat;
        r_cmp_care <= n_cmp_care;
        r_len_ok   <= n_len_ok;
    end

    // handshake
    assign out_free = !r_out_valid || i_ready;
    assign adv      = r_in_valid && (!r_in_end || out_free);
    assign o_ready  = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_data_byte;
            r_in_end  <= i_region_end;
        end
    end

    // window compare and position
    always_comb begin
        n_win[0] = r_in_byte;
        for (int a = 1; a < MAX_PATTERN; a++) begin
            n_win[a] = r_win[a-1];
        end
        win_ok = 1'b1;
        for (int a = 0; a < MAX_PATTERN; a++) begin
            win_ok = win_ok && (!r_cmp_care[a] || (n_win[a] == r_cmp_pat[a]));
        end
        n_count = (r_count == '1) ? r_count : r_count + CNT_W'(1);
        hit     = r_len_ok && (n_count >= CNT_W'(r_len)) && win_ok;
        n_seen  = r_seen || hit;
        n_pos   = r_seen ? r_pos : n_count - CNT_W'(r_len);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_seen  <= 1'b0;
            r_pos   <= '0;
        end else if (adv) begin
            if (r_in_end) begin
                r_count <= '0;
                r_seen  <= 1'b0;
                r_pos   <= '0;
            end else begin
                r_count <= n_count;
                r_seen  <= n_seen;
                r_pos   <= n_pos;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in_end) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_end) begin
            r_out_found <= n_seen;
            r_out_addr  <= n_seen ? ADDR_W'(n_pos) + ADDR_W'(r_ofs) : '0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_found         = r_out_found;
    assign o_match_address = r_out_addr;

endmodule

>>> rtl/wbps_checker.sv
// ----------------------------------------------------------------------------
// wbps_checker
// port-level checks for the wildcard byte pattern search core
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wbps_checker (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    o_ready,
    input  logic                    o_valid,
    input  logic                    i_ready,
    input  logic                    o_found,
    input  logic [wbps_pkg::ADDR_W-1:0] o_match_address
);

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_found) && $stable(o_match_address),
        "result changed while stalled")

    // not found reports a zero address
    `ASSERT_IMPL(a_miss_zero, i_clk, i_rst_n, o_valid && !o_found,
        o_match_address == '0, "nonzero address without a match")

    // reset empties the result register
    `ASSERT_NEXT(a_rst_clear, i_clk, 1'b1, !i_rst_n, !o_valid, "result valid after reset")

    // with no pending result the input side never stalls
    `ASSERT_IMPL(a_empty_ready, i_clk, i_rst_n, !o_valid, o_ready,
        "input stalled with empty result register")

endmodule

bind wildcard_byte_pattern_search_core wbps_checker u_wbps_checker (.*);

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// testbench for the wildcard byte pattern search core
// ----------------------------------------------------------------------------
// Streams byte regions through the core under several pattern settings and
// predicts each region report in a scoreboard with its own sliding window.
// Regions mostly carry planted copies of the pattern among random or
// near-miss bytes. Both sides idle at random until 700 bytes have been sent.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wbps_pkg::*;

    localparam int MAX_PATTERN    = 32;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TOTAL_BYTES    = 1075;
    localparam t_cfg_idx REG_UNUSED = 3'd7;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] address;
    } t_scan_report;

    class t_scan_scoreboard;
        t_pat_regs         pat_regs;
        logic [LEN_W-1:0]  pat_len;
        t_byte             wild;
        logic [OFS_W-1:0]  offset;
        t_byte             window [MAX_PATTERN];
        logic [CNT_W-1:0]  byte_count;
        logic              match_seen;
        logic [CNT_W-1:0]  match_pos;
        t_scan_report      pending_reports [$];
        int                mismatches;

        function new();
            pat_regs   = '0;
            pat_len    = '0;
            wild       = '0;
            offset     = '0;
            mismatches = 0;
            clear_region();
        endfunction

        function void clear_region();
            foreach (window[i]) window[i] = '0;
            byte_count = '0;
            match_seen = 1'b0;
            match_pos  = '0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: pat_regs[idx[1:0]] = data;
                REG_LEN:    pat_len = data[LEN_W-1:0];
                REG_WILD:   wild    = data[DATA_W-1:0];
                REG_OFFSET: offset  = data[OFS_W-1:0];
                default: ;
            endcase
        endfunction

        function bit window_hit();
            t_byte p;
            int    age;
            for (int k = 0; k < int'(pat_len); k++) begin
                p   = pat_regs[k / 8][(k % 8) * 8 +: 8];
                age = int'(pat_len) - 1 - k;
                if (p != wild && window[age] != p) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void take_byte(t_byte value, logic last);
            t_scan_report rep;
            for (int i = MAX_PATTERN - 1; i > 0; i--) window[i] = window[i - 1];
            window[0] = value;
            if (byte_count != '1) byte_count++;
            if (!match_seen && pat_len != 0 && pat_len <= MAX_PATTERN &&
                byte_count >= pat_len && window_hit()) begin
                match_seen = 1'b1;
                match_pos  = byte_count - pat_len;
            end
            if (last) begin
                rep.found   = match_seen;
                rep.address = match_seen ? {1'b0, match_pos} + ADDR_W'(offset) : '0;
                pending_reports.push_back(rep);
                clear_region();
            end
        endfunction

        function void check_report(logic found, logic [ADDR_W-1:0] address);
            t_scan_report exp;
            if (pending_reports.size() == 0) begin
                $display("%0t: report with none pending, found %0d address %0h",
                         $time, found, address);
                mismatches++;
                return;
            end
            exp = pending_reports.pop_front();
            if (found !== exp.found) begin
                $display("%0t: found expected %0d actual %0d", $time, exp.found, found);
                mismatches++;
            end
            if (address !== exp.address) begin
                $display("%0t: match_address expected %0h actual %0h",
                         $time, exp.address, address);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction
    endclass

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_cfg_we     = 1'b0;
    t_cfg_idx          i_cfg_idx    = REG_PAT0;
    logic [CFG_W-1:0]  i_cfg_data   = '0;
    logic              i_valid      = 1'b0;
    t_byte             i_data_byte  = '0;
    logic              i_region_end = 1'b0;
    logic              i_ready      = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic              o_found;
    logic [ADDR_W-1:0] o_match_address;

    t_scan_scoreboard  sb;
    int                send_idle_pct  = 13;
    int                recv_stall_pct = 74;
    int                bytes_sent     = 0;
    int                quiet_cycles   = 0;
    t_byte             cur_pat [MAX_PATTERN];
    int                cur_len;
    t_byte             cur_wild;
    logic [OFS_W-1:0]  cur_offset;

    wildcard_byte_pattern_search_core #(
        .MAX_PATTERN(MAX_PATTERN)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_region_end    (i_region_end),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_found         (o_found),
        .o_match_address (o_match_address)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_ready <= (int'($urandom_range(0, 99)) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.take_byte(i_data_byte, i_region_end);
            if (o_valid && i_ready) sb.check_report(o_found, o_match_address);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_byte(input t_byte value, input logic last);
        if (bytes_sent < 350) begin
            send_idle_pct  = 13;
            recv_stall_pct = 74;
        end else if (bytes_sent < 700) begin
            send_idle_pct  = 74;
            recv_stall_pct = 13;
        end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
        if (int'($urandom_range(0, 99)) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_byte  <= value;
        i_region_end <= last;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
    endtask

    // drain all reports, then let the pipeline empty before touching registers
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_scan();
        t_pat_regs        regs;
        logic [CFG_W-1:0] word;
        t_cfg_idx         order [8];
        order = '{REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3,
                  REG_LEN, REG_WILD, REG_OFFSET, REG_UNUSED};
        for (int k = 0; k < MAX_PATTERN; k++) regs[k / 8][(k % 8) * 8 +: 8] = cur_pat[k];
        i_cfg_we <= 1'b1;
        for (int k = 0; k < 8; k++) begin
            word = {$urandom, $urandom};
            case (order[k])
                REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: word = regs[order[k][1:0]];
                REG_LEN:    word[LEN_W-1:0]  = cur_len[LEN_W-1:0];
                REG_WILD:   word[DATA_W-1:0] = cur_wild;
                REG_OFFSET: word[OFS_W-1:0]  = cur_offset;
                default: ;
            endcase
            i_cfg_idx  <= order[k];
            i_cfg_data <= word;
            sb.write_reg(order[k], word);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        repeat (2) @(posedge i_clk);
    endtask

    function automatic void pick_setting();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)       cur_len = 0;
        else if (r < 12) cur_len = $urandom_range(33, 63);
        else if (r < 20) cur_len = MAX_PATTERN;
        else if (r < 35) cur_len = $urandom_range(9, 31);
        else             cur_len = $urandom_range(1, 8);
        cur_wild = t_byte'($urandom);
        r = $urandom_range(0, 99);
        for (int k = 0; k < MAX_PATTERN; k++)
            cur_pat[k] = (r < 8 || $urandom_range(0, 3) == 0) ? cur_wild : t_byte'($urandom);
        r = $urandom_range(0, 99);
        if (r < 10)      cur_offset = '0;
        else if (r < 20) cur_offset = '1;
        else             cur_offset = OFS_W'($urandom);
    endfunction

    task automatic scan_random_region();
        t_byte region [64];
        int    eff;
        int    n;
        int    pos;
        int    plants;
        bit    near;
        eff = (cur_len > MAX_PATTERN) ? MAX_PATTERN : cur_len;
        if ($urandom_range(0, 9) == 0) n = $urandom_range(1, (cur_len < 1) ? 1 : cur_len);
        else                           n = $urandom_range(1, eff + 16);
        near = $urandom_range(0, 1);
        for (int i = 0; i < n; i++)
            region[i] = (near && eff > 0) ? cur_pat[$urandom_range(0, eff - 1)]
                                          : t_byte'($urandom);
        plants = $urandom_range(0, 3);
        if (cur_len > 0 && cur_len <= MAX_PATTERN && n >= cur_len) begin
            repeat (plants) begin
                pos = $urandom_range(0, n - cur_len);
                for (int k = 0; k < cur_len; k++)
                    region[pos + k] = (cur_pat[k] == cur_wild) ? t_byte'($urandom) : cur_pat[k];
            end
        end
        for (int i = 0; i < n; i++) send_byte(region[i], i == n - 1);
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pattern after reset
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        settle();

        // three-byte pattern with a wildcard in the middle, top offset
        foreach (cur_pat[k]) cur_pat[k] = 8'h00;
        cur_pat[0] = 8'hAB;
        cur_pat[1] = 8'h5A;
        cur_pat[2] = 8'hCD;
        cur_len    = 3;
        cur_wild   = 8'h5A;
        cur_offset = 16'hFFFF;
        program_scan();
        send_byte(8'h00, 1'b0);
        send_byte(8'hAB, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hCD, 1'b1);
        send_byte(8'hAB, 1'b0);
        send_byte(8'hCD, 1'b1);
        send_byte(8'hAB, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'hCD, 1'b0);
        send_byte(8'hAB, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'hCD, 1'b1);
        settle();

        // all-wildcard pattern
        foreach (cur_pat[k]) cur_pat[k] = 8'hFF;
        cur_len    = 4;
        cur_wild   = 8'hFF;
        cur_offset = 16'h0000;
        program_scan();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7E, 1'b1);
        settle();

        // oversize pattern length
        foreach (cur_pat[k]) cur_pat[k] = 8'h00;
        cur_len    = 40;
        cur_wild   = 8'h00;
        cur_offset = 16'h1234;
        program_scan();
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);

        while (bytes_sent < TOTAL_BYTES) begin
            settle();
            pick_setting();
            program_scan();
            repeat ($urandom_range(3, 10)) scan_random_region();
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
